FILE: rtl/utsan_pkg.sv
// Shared types and constants for the UTF-8 text sanitiser.
// Used by the front, queue, back and checker modules and by the top level.
package utsan_pkg;

  localparam int CP_W    = 21;
  localparam int COUNT_W = 12;
  localparam int REP_W   = 3;
  localparam int SLOTS   = 5;
  localparam int SLOT_W  = 3;

  typedef enum logic {
    CMD_TEXT = 1'b0,
    CMD_END  = 1'b1
  } command_t;

  localparam logic [CP_W-1:0]    CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0]    CP_SPACE       = 21'h000020;
  localparam logic [CP_W-1:0]    CP_TAB         = 21'h000009;
  localparam logic [CP_W-1:0]    CP_NBSP        = 21'h0000A0;
  localparam logic [CP_W-1:0]    CP_IDEO_SPACE  = 21'h003000;
  localparam logic [CP_W-1:0]    CP_DEL         = 21'h00007F;
  localparam logic [CP_W-1:0]    CP_C1_FIRST    = 21'h000080;
  localparam logic [CP_W-1:0]    CP_C1_LAST     = 21'h00009F;
  localparam logic [CP_W-1:0]    CP_TWO_BYTE    = 21'h000800;
  localparam logic [CP_W-1:0]    CP_THREE_BYTE  = 21'h010000;
  localparam logic [7:0]         BYTE_SPACE     = 8'h20;
  localparam logic [COUNT_W-1:0] LENGTH_LIMIT_RESET = 12'd32;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
  } out_item_t;

  // One decoded input word: a run of replacement characters, then an
  // optional code point, then optionally the end of the text.
  typedef struct packed {
    logic [REP_W-1:0] rep_count;
    logic             has_cp;
    logic [CP_W-1:0]  cp;
    logic             is_end;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: rtl/utsan_front.sv
// Front section: accepts input words and decodes UTF-8 into tokens.
// Depends on utsan_pkg; feeds utsan_fifo.
module utsan_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  utsan_pkg::in_item_t   in_data,
  input  utsan_pkg::fifo_status_t q_status,
  output logic                  push,
  output utsan_pkg::token_t     push_token
);
  import utsan_pkg::*;

  logic [1:0]      needed, needed_next;
  logic [1:0]      received, received_next;
  logic [CP_W-1:0] partial, partial_next;
  logic            deferred, deferred_next;

  logic            accept;
  logic [7:0]      b;
  logic            cont;
  logic            broke;
  logic [1:0]      recv_inc;
  logic [CP_W-1:0] accumulated;
  logic [REP_W-1:0] flush_n;
  token_t          tok;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    b             = in_data.data_byte;
    cont          = (b[7:6] == 2'b10);
    broke         = (needed != 2'd0);
    recv_inc      = received + 2'd1;
    accumulated   = {partial[CP_W-7:0], b[5:0]};
    flush_n       = broke ? ({1'b0, received} + 3'd1) : 3'd0;
    needed_next   = needed;
    received_next = received;
    partial_next  = partial;
    deferred_next = deferred;
    tok           = '0;
    tok.rep_count = {2'b00, deferred};
    if (accept) begin
      deferred_next = 1'b0;
      if (in_data.command == CMD_END) begin
        tok.rep_count = tok.rep_count + flush_n;
        tok.is_end    = 1'b1;
        needed_next   = 2'd0;
        received_next = 2'd0;
        partial_next  = '0;
      end else if (broke && cont) begin
        partial_next  = accumulated;
        received_next = recv_inc;
        if (recv_inc >= needed) begin
          tok.has_cp    = 1'b1;
          tok.cp        = accumulated;
          needed_next   = 2'd0;
          received_next = 2'd0;
          partial_next  = '0;
        end
      end else begin
        // A sequence cut short is flushed first; the breaking byte then
        // starts afresh as a lead byte.
        tok.rep_count = tok.rep_count + flush_n;
        needed_next   = 2'd0;
        received_next = 2'd0;
        partial_next  = '0;
        if (!b[7]) begin
          tok.has_cp = 1'b1;
          tok.cp     = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          partial_next = {16'd0, b[4:0]};
          needed_next  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          partial_next = {17'd0, b[3:0]};
          needed_next  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          partial_next = {18'd0, b[2:0]};
          needed_next  = 2'd3;
        end else if (broke) begin
          // Keeps every input word within the result budget.
          deferred_next = 1'b1;
        end else begin
          tok.has_cp = 1'b1;
          tok.cp     = CP_REPLACEMENT;
        end
      end
    end
  end

  assign push       = accept && ((tok.rep_count != '0) || tok.has_cp || tok.is_end);
  assign push_token = tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      needed   <= 2'd0;
      received <= 2'd0;
      partial  <= '0;
      deferred <= 1'b0;
    end else begin
      needed   <= needed_next;
      received <= received_next;
      partial  <= partial_next;
      deferred <= deferred_next;
    end
  end

endmodule

FILE: rtl/utsan_fifo.sv
// Short token queue between the front and back sections.
// Depends on utsan_pkg for the token and status types.
module utsan_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  utsan_pkg::token_t       push_token,
  input  logic                    pop,
  output utsan_pkg::token_t       head,
  output utsan_pkg::fifo_status_t status
);
  import utsan_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  token_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/utsan_back.sv
// Back section: filters code points, applies the length limit and re-encodes
// as UTF-8, one result word a cycle unless stalled. Depends on utsan_pkg.
module utsan_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [11:0]             cfg_wdata,
  input  utsan_pkg::fifo_status_t q_status,
  input  utsan_pkg::token_t       head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output utsan_pkg::out_item_t    out_data
);
  import utsan_pkg::*;

  logic [COUNT_W-1:0] length_limit;
  logic [COUNT_W-1:0] emitted_count, emitted_count_next;
  logic               pending_sep, pending_sep_next;
  logic               truncated, truncated_next;
  logic [REP_W-1:0]   reps_done, reps_done_next;
  logic               cp_done, cp_done_next;
  out_item_t          slots [SLOTS];
  logic [SLOT_W-1:0]  slot_count;

  logic               move, slots_free, step;
  logic               is_rep, is_cp, is_term, more;
  logic [CP_W-1:0]    cp;
  logic               is_sep, is_ctrl, fits, emit, load;
  logic [COUNT_W:0]   sum;
  logic [7:0]         u [4];
  logic [SLOT_W-1:0]  ulen;
  out_item_t          new_slots [SLOTS];
  logic [SLOT_W-1:0]  new_count;

  assign move       = (slot_count != '0) && (!out_valid || !out_stall);
  assign slots_free = (slot_count == '0) || ((slot_count == SLOT_W'(1)) && move);
  assign step       = !q_status.empty && slots_free;

  always_comb begin
    is_rep  = (reps_done != head.rep_count);
    is_cp   = !is_rep && head.has_cp && !cp_done;
    is_term = !is_rep && !is_cp;
    cp      = is_rep ? CP_REPLACEMENT : head.cp;
    if (is_rep) begin
      more = ((reps_done + 3'd1) != head.rep_count) || head.has_cp || head.is_end;
    end else if (is_cp) begin
      more = head.is_end;
    end else begin
      more = 1'b0;
    end
  end

  assign pop = step && !more;

  always_comb begin
    reps_done_next = reps_done;
    cp_done_next   = cp_done;
    if (pop) begin
      reps_done_next = '0;
      cp_done_next   = 1'b0;
    end else if (step && is_rep) begin
      reps_done_next = reps_done + 3'd1;
    end else if (step && is_cp) begin
      cp_done_next = 1'b1;
    end
  end

  // UTF-8 encoding of the selected code point.
  always_comb begin
    u[0] = cp[7:0];
    u[1] = 8'h00;
    u[2] = 8'h00;
    u[3] = 8'h00;
    ulen = SLOT_W'(1);
    if (cp >= CP_THREE_BYTE) begin
      u[0] = {5'b11110, cp[20:18]};
      u[1] = {2'b10, cp[17:12]};
      u[2] = {2'b10, cp[11:6]};
      u[3] = {2'b10, cp[5:0]};
      ulen = SLOT_W'(4);
    end else if (cp >= CP_TWO_BYTE) begin
      u[0] = {4'b1110, cp[15:12]};
      u[1] = {2'b10, cp[11:6]};
      u[2] = {2'b10, cp[5:0]};
      ulen = SLOT_W'(3);
    end else if (cp >= CP_C1_FIRST) begin
      u[0] = {3'b110, cp[10:6]};
      u[1] = {2'b10, cp[5:0]};
      ulen = SLOT_W'(2);
    end
  end

  always_comb begin
    is_sep  = (cp == CP_SPACE) || (cp == CP_TAB) || (cp == CP_NBSP) || (cp == CP_IDEO_SPACE);
    is_ctrl = (cp < CP_SPACE) || (cp == CP_DEL) || ((cp >= CP_C1_FIRST) && (cp <= CP_C1_LAST));
    // A pending space needs room for the character after it as well.
    sum     = {1'b0, emitted_count} + (pending_sep ? 13'd2 : 13'd1);
    fits    = (sum <= {1'b0, length_limit});
    emit    = step && !is_term && !truncated && !is_sep && !is_ctrl && fits;
    load    = emit || (step && is_term);

    emitted_count_next = emitted_count;
    pending_sep_next   = pending_sep;
    truncated_next     = truncated;
    if (step && is_term) begin
      emitted_count_next = '0;
      pending_sep_next   = 1'b0;
      truncated_next     = 1'b0;
    end else if (step && !truncated) begin
      if (is_sep) begin
        if (emitted_count != '0) begin
          pending_sep_next = 1'b1;
        end
      end else if (!is_ctrl) begin
        if (!fits) begin
          truncated_next = 1'b1;
        end else begin
          emitted_count_next = sum[COUNT_W-1:0];
          pending_sep_next   = 1'b0;
        end
      end
    end

    for (int i = 0; i < SLOTS; i++) begin
      new_slots[i] = '{out_byte: 8'h00, has_byte: 1'b1, end_of_text: 1'b0};
    end
    new_count = ulen;
    if (is_term) begin
      new_slots[0] = '{out_byte: 8'h00, has_byte: 1'b0, end_of_text: 1'b1};
      new_count    = SLOT_W'(1);
    end else if (pending_sep) begin
      new_slots[0].out_byte = BYTE_SPACE;
      for (int i = 0; i < 4; i++) begin
        new_slots[i+1].out_byte = u[i];
      end
      new_count = ulen + SLOT_W'(1);
    end else begin
      for (int i = 0; i < 4; i++) begin
        new_slots[i].out_byte = u[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= new_slots[i];
      end
    end else if (move) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
    if (move) begin
      out_data <= slots[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit  <= LENGTH_LIMIT_RESET;
      emitted_count <= '0;
      pending_sep   <= 1'b0;
      truncated     <= 1'b0;
      reps_done     <= '0;
      cp_done       <= 1'b0;
      slot_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        length_limit <= cfg_wdata;
      end
      emitted_count <= emitted_count_next;
      pending_sep   <= pending_sep_next;
      truncated     <= truncated_next;
      reps_done     <= reps_done_next;
      cp_done       <= cp_done_next;
      if (load) begin
        slot_count <= new_count;
      end else if (move) begin
        slot_count <= slot_count - SLOT_W'(1);
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/utf8_text_sanitizer_core.sv
// The sanitiser takes one input word a cycle while its token queue has room and
// delivers at most one result word a cycle. The back section works through each
// decoded code point (dropped spaces and control characters included), then each
// further byte it writes (a space written before the character included), and the
// closing word one by one, so a stream of ASCII text runs at one word a cycle and
// wider characters at one output byte a cycle while the receiver does not stall.
// A word's first result is registered in the token queue, then in the result slots
// and then in the output register, from which it is presented. An end word flushes
// any cut sequence, yields one closing word and clears the text state.
// Depends on utsan_pkg, utsan_front, utsan_fifo and utsan_back.
module utf8_text_sanitizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  utsan_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output utsan_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [11:0]          cfg_wdata
);
  import utsan_pkg::*;

  fifo_status_t q_status;
  logic         push;
  token_t       push_token;
  token_t       head;
  logic         pop;

  utsan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_token (push_token)
  );

  utsan_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  utsan_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/utsan_checker.sv
// Port-level checks for the UTF-8 text sanitiser, bound to its top level.
// Depends on utsan_pkg and utf8_text_sanitizer_core.
module utsan_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input utsan_pkg::out_item_t out_data
);
  import utsan_pkg::*;

  // A stalled word is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed or was dropped");

  // The closing word carries no byte, and a byte word never closes the text.
  a_close_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.has_byte != out_data.end_of_text) &&
                  (out_data.has_byte || out_data.out_byte == 8'h00))
    else $error("malformed closing word");

  // Control characters never leave the block, and lead bytes stay in range.
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.has_byte |->
      out_data.out_byte >= BYTE_SPACE && out_data.out_byte != 8'h7F &&
      out_data.out_byte != 8'hC0 && out_data.out_byte != 8'hC1 &&
      out_data.out_byte < 8'hF8)
    else $error("output byte outside sanitised range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind utf8_text_sanitizer_core utsan_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/tb_top.sv
// Self-checking testbench for utf8_text_sanitizer_core: a directed table, then random texts.
// Each accepted word is run through a behavioural sanitiser and the outputs are checked
// in order. Depends on utsan_pkg and the RTL under rtl/.
module tb_top;
  import utsan_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES   = 32;
  localparam logic [CP_W-1:0] CP_ASCII_END = 21'h000080;
  localparam out_item_t CLOSING_WORD = '{out_byte: 8'h00, has_byte: 1'b0, end_of_text: 1'b1};

  // One stimulus word; where typed is set, the results are written out in the row
  // (up to three bytes, first byte in the top bits, then an optional closing word).
  typedef struct packed {
    command_t    command;
    logic [7:0]  data_byte;
    logic        typed;
    logic [1:0]  n_bytes;
    logic [23:0] bytes;
    logic        closes;
  } stim_row_t;

  typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  localparam stim_row_t DIRECTED_ROWS [28] = '{
    '{CMD_TEXT, 8'h20, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h41, 1'b1, 2'd1, 24'h410000, 1'b0},
    '{CMD_TEXT, 8'h20, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h00, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h7F, 1'b1, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hC2, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hA0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hE3, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h80, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h80, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hC3, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hA9, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hF0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h9F, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h98, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h80, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hC2, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h85, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h80, 1'b1, 2'd3, 24'hEFBFBD, 1'b0},
    '{CMD_TEXT, 8'hFF, 1'b1, 2'd3, 24'hEFBFBD, 1'b0},
    '{CMD_TEXT, 8'hE2, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h82, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h41, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hF0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hFF, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'h09, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_TEXT, 8'hE0, 1'b0, 2'd0, 24'h000000, 1'b0},
    '{CMD_END,  8'hFF, 1'b0, 2'd0, 24'h000000, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [11:0] cfg_wdata;

  utf8_text_sanitizer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  out_item_t   expected_words[$];
  stim_row_t   offered_words[$];
  int unsigned fail_count    = 0;
  int unsigned words_offered = 0;
  int unsigned burst_left    = 0;
  bit          hold_off_req  = 1'b0;

  // Sanitiser state as the block should hold it.
  int unsigned     max_cps      = LENGTH_LIMIT_RESET;
  logic [1:0]      dec_need     = '0;
  logic [1:0]      dec_got      = '0;
  logic [CP_W-1:0] dec_cp       = '0;
  bit              space_pending = 1'b0;
  int unsigned     cp_written   = 0;
  bit              text_cut     = 1'b0;
  bit              held_fffd    = 1'b0;

  function automatic void queue_word(out_item_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    out_item_t w;
    w = '{out_byte: b, has_byte: 1'b1, end_of_text: 1'b0};
    queue_word(w);
  endfunction

  function automatic void encode_cp(logic [CP_W-1:0] cp);
    if (cp < CP_ASCII_END) begin
      push_byte(cp[7:0]);
    end else if (cp < CP_TWO_BYTE) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp < CP_THREE_BYTE) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endfunction

  // A space is only written together with the character after it, so it needs two free slots.
  function automatic void admit_cp(logic [CP_W-1:0] cp);
    int unsigned need;
    if (text_cut) return;
    if (cp == CP_SPACE || cp == CP_TAB || cp == CP_NBSP || cp == CP_IDEO_SPACE) begin
      if (cp_written != 0) space_pending = 1'b1;
      return;
    end
    if (cp < CP_SPACE || cp == CP_DEL || (cp >= CP_C1_FIRST && cp <= CP_C1_LAST)) return;
    need = space_pending ? 2 : 1;
    if (cp_written + need > max_cps) begin
      text_cut = 1'b1;
      return;
    end
    if (space_pending) begin
      push_byte(BYTE_SPACE);
      cp_written++;
      space_pending = 1'b0;
    end
    encode_cp(cp);
    cp_written = (cp_written + 1) & 12'hFFF;
  endfunction

  function automatic void flush_cut_sequence();
    if (dec_need == 0) return;
    for (int k = 0; k <= dec_got; k++) admit_cp(CP_REPLACEMENT);
    dec_need = '0;
    dec_got  = '0;
    dec_cp   = '0;
  endfunction

  function automatic void predict_sanitised(in_item_t w);
    logic [7:0]      b;
    logic [CP_W-1:0] cp;
    bit              broke;
    b     = w.data_byte;
    broke = 1'b0;
    if (held_fffd) begin
      held_fffd = 1'b0;
      admit_cp(CP_REPLACEMENT);
    end
    if (w.command == CMD_END) begin
      flush_cut_sequence();
      queue_word(CLOSING_WORD);
      space_pending = 1'b0;
      cp_written    = 0;
      text_cut      = 1'b0;
      return;
    end
    if (dec_need != 0) begin
      if (b[7:6] == 2'b10) begin
        dec_cp = {dec_cp[14:0], b[5:0]};
        dec_got++;
        if (dec_got >= dec_need) begin
          cp       = dec_cp;
          dec_need = '0;
          dec_got  = '0;
          dec_cp   = '0;
          admit_cp(cp);
        end
        return;
      end
      flush_cut_sequence();
      broke = 1'b1;
    end
    if (b[7] == 1'b0) begin
      admit_cp({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      dec_cp   = {16'd0, b[4:0]};
      dec_need = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      dec_cp   = {17'd0, b[3:0]};
      dec_need = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      dec_cp   = {18'd0, b[2:0]};
      dec_need = 2'd3;
    end else if (broke) begin
      // A stray byte that breaks a sequence has its replacement held for the next word.
      held_fffd = 1'b1;
    end else begin
      admit_cp(CP_REPLACEMENT);
    end
    dec_got = '0;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t   exp_word;
    stim_row_t   note;
    int unsigned base;
    if (!rst) begin
      if (cfg_we) max_cps = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: out_byte %02h has_byte %0d end_of_text %0d",
                 out_data.out_byte, out_data.has_byte, out_data.end_of_text);
          fail_count++;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_data.out_byte !== exp_word.out_byte) begin
            $error("out_byte: expected %02h, got %02h", exp_word.out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.has_byte !== exp_word.has_byte) begin
            $error("has_byte: expected %0d, got %0d", exp_word.has_byte, out_data.has_byte);
            fail_count++;
          end
          if (out_data.end_of_text !== exp_word.end_of_text) begin
            $error("end_of_text: expected %0d, got %0d", exp_word.end_of_text,
                   out_data.end_of_text);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        note = offered_words.pop_front();
        base = expected_words.size();
        predict_sanitised(in_data);
        // Rows with written-out results replace the predicted ones; the state still advances.
        if (note.typed) begin
          while (expected_words.size() > base) expected_words.delete(expected_words.size() - 1);
          for (int k = 0; k < note.n_bytes; k++) push_byte(note.bytes[23 - 8 * k -: 8]);
          if (note.closes) queue_word(CLOSING_WORD);
        end
      end
    end
  end

  // Receiver: a stall pattern that changes at random intervals, plus a long hold-off on request.
  initial begin : receiver
    stall_mode_t mode;
    int unsigned left;
    int unsigned tick;
    out_stall = 1'b0;
    mode = STALL_NONE;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall <= ((tick % 5) < 2);
          default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Called and returning at a falling edge; the sender works in bursts with gaps between.
  task automatic send_word(stim_row_t row);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{command: row.command, data_byte: row.data_byte};
    offered_words.push_back(row);
    words_offered++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word('{CMD_TEXT, b, 1'b0, 2'd0, 24'd0, 1'b0});
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_byte(int unsigned conts);
    case (conts)
      1:       return 8'hC0 | 8'($urandom_range(0, 31));
      2:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // A lead byte with fewer continuations than it asks for.
  task automatic send_partial();
    int unsigned conts;
    conts = $urandom_range(1, 3);
    send_byte(lead_byte(conts));
    repeat ($urandom_range(0, conts - 1)) send_byte(cont_byte());
  endtask

  task automatic send_char();
    int unsigned pick;
    int unsigned conts;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_byte(8'($urandom_range(8'h21, 8'h7E)));
    end else if (pick < 40) begin
      case ($urandom_range(0, 3))
        0: send_byte(BYTE_SPACE);
        1: send_byte(CP_TAB[7:0]);
        2: begin
          send_byte(8'hC2);
          send_byte(8'hA0);
        end
        default: begin
          send_byte(8'hE3);
          send_byte(8'h80);
          send_byte(8'h80);
        end
      endcase
    end else if (pick < 45) begin
      case ($urandom_range(0, 2))
        0: send_byte(8'($urandom_range(0, 31)));
        1: send_byte(CP_DEL[7:0]);
        default: begin
          send_byte(8'hC2);
          send_byte(8'h80 | 8'($urandom_range(0, 31)));
        end
      endcase
    end else if (pick < 80) begin
      conts = (pick < 60) ? 1 : (pick < 72) ? 2 : 3;
      send_byte(lead_byte(conts));
      repeat (conts) send_byte(cont_byte());
    end else if (pick < 85) begin
      send_byte(cont_byte());
    end else if (pick < 89) begin
      send_byte(8'($urandom_range(8'hF8, 8'hFF)));
    end else if (pick < 96) begin
      send_partial();
      case ($urandom_range(0, 2))
        0:       send_byte(8'($urandom_range(0, 8'h7F)));
        1:       send_byte(lead_byte($urandom_range(1, 3)));
        default: send_byte(8'($urandom_range(8'hF8, 8'hFF)));
      endcase
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // Whole texts, mostly short, some cut off inside a sequence by the end word.
  task automatic run_texts(int unsigned word_goal);
    int unsigned start;
    int unsigned n_chars;
    start = words_offered;
    while (words_offered - start < word_goal) begin
      n_chars = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 6);
      repeat (n_chars) send_char();
      if ($urandom_range(0, 3) == 0) send_partial();
      send_word('{CMD_END, 8'($urandom), 1'b0, 2'd0, 24'd0, 1'b0});
    end
  endtask

  // Words that yield nothing may still be in flight once the last result is in.
  task automatic drain();
    while (offered_words.size() != 0 || expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [11:0] phase_max [7];
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    phase_max = '{12'd0, 12'd1, 12'd2, 12'd5, 12'd4095, 12'd0, 12'd32};
    phase_max[5] = 12'($urandom_range(0, 4095));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) send_word(DIRECTED_ROWS[i]);
    in_valid <= 1'b0;
    drain();

    foreach (phase_max[p]) begin
      cfg_wdata <= phase_max[p];
      cfg_we    <= 1'b1;
      @(negedge clk);
      cfg_we <= 1'b0;
      // The widest setting gives the most output, so that is where the receiver holds off.
      if (phase_max[p] == 12'd4095) hold_off_req = 1'b1;
      run_texts((phase_max[p] == 12'd4095) ? 10 : 2);
      in_valid <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("utf8_text_sanitizer_core: match");
    end else begin
      $display("utf8_text_sanitizer_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("utf8_text_sanitizer_core: mismatch");
    $finish;
  end

endmodule

FILE: utf8_text_sanitizer_core.f
rtl/utsan_pkg.sv
rtl/utsan_front.sv
rtl/utsan_fifo.sv
rtl/utsan_back.sv
rtl/utf8_text_sanitizer_core.sv
rtl/utsan_checker.sv
verif/tb_top.sv
